[rtl/pattern_mask_filter_defines.svh]
// ----------------------------------------------------------------------------
// pattern_mask_filter_defines: assertion macros shared by the filter RTL
// Each macro expands to one labeled concurrent assertion on i_clk that is
// switched off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PATTERN_MASK_FILTER_DEFINES_SVH
`define PATTERN_MASK_FILTER_DEFINES_SVH

// Same-cycle implication: when ante holds, cons must hold at that edge.
`define PMF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define PMF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/pmf_pkg.sv]
// ----------------------------------------------------------------------------
// pmf_pkg: shared types and constants of the pattern mask filter
// Register indexes, fixed field widths and the cell control bundle.
// ----------------------------------------------------------------------------
package pmf_pkg;

    // Default window depth in cells
    localparam int MAX_PATTERN_DEF = 32;

    // Configuration port geometry
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int LEN_REG_W  = 6;
    localparam int PAT_WORDS  = 4;
    localparam int PAT_BYTES  = PAT_WORDS * (CFG_DATA_W / 8);

    // Byte that replaces every pattern byte on a match
    localparam logic [7:0] STAR_BYTE = 8'h2A;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEN  = 3'd0,
        CFG_PAT0 = 3'd1,
        CFG_PAT1 = 3'd2,
        CFG_PAT2 = 3'd3,
        CFG_PAT3 = 3'd4
    } t_cfg_idx;

    // Control from the sequencer to every cell of the window
    typedef struct packed {
        logic insert;   // write the accepted byte into the cell at the fill count
        logic shift;    // move every byte one cell toward the head
    } t_cell_ctl;

endpackage

[rtl/pmf_cfg.sv]
// ----------------------------------------------------------------------------
// pmf_cfg: configuration registers of the pattern mask filter
// Holds the pattern length and pattern words, and derives the effective
// length (zero taken as one, large values clipped to the window depth).
// ----------------------------------------------------------------------------
module pmf_cfg
    import pmf_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    localparam int CW = $clog2(MAX_PATTERN + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [CW-1:0]         o_len,
    output logic [7:0]            o_pat [MAX_PATTERN]
);

    logic [LEN_REG_W-1:0]  r_len;
    logic [CFG_DATA_W-1:0] r_pat [PAT_WORDS];
    logic [LEN_REG_W:0]    w_len_ext;

    // Capture register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_REG_W'(1);
            for (int k = 0; k < PAT_WORDS; k++) begin
                r_pat[k] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LEN:  r_len    <= i_cfg_data[LEN_REG_W-1:0];
                CFG_PAT0: r_pat[0] <= i_cfg_data;
                CFG_PAT1: r_pat[1] <= i_cfg_data;
                CFG_PAT2: r_pat[2] <= i_cfg_data;
                CFG_PAT3: r_pat[3] <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    // Clamp the length into 1..MAX_PATTERN
    assign w_len_ext = {1'b0, r_len};

    always_comb begin
        if (r_len == '0) begin
            o_len = CW'(1);
        end else if (w_len_ext > (LEN_REG_W + 1)'(MAX_PATTERN)) begin
            o_len = CW'(MAX_PATTERN);
        end else begin
            o_len = CW'(w_len_ext);
        end
    end

    // Spread the pattern words into one byte per cell; bytes past the words read zero
    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_pat
        if (g < PAT_BYTES) begin : g_word
            assign o_pat[g] = r_pat[g / 8][8 * (g % 8) +: 8];
        end else begin : g_zero
            assign o_pat[g] = '0;
        end
    end

endmodule

[rtl/pmf_cell.sv]
// ----------------------------------------------------------------------------
// pmf_cell: one byte cell of the pending window
// Holds one pending byte, takes the accepted byte when the fill count points
// here, compares against its pattern byte and hands its byte to the neighbor
// toward the head on a shift.
// ----------------------------------------------------------------------------
module pmf_cell
    import pmf_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int IDX         = 0,
    localparam int CW = $clog2(MAX_PATTERN + 1)
) (
    input  logic          i_clk,
    input  t_cell_ctl     i_ctl,
    input  logic [CW-1:0] i_count,
    input  logic [CW-1:0] i_len,
    input  logic [7:0]    i_text_byte,
    input  logic [7:0]    i_pat_byte,
    input  logic [7:0]    i_right_byte,
    output logic [7:0]    o_eff_byte,
    output logic          o_match_ok
);

    logic [7:0] r_byte;
    logic [7:0] n_byte;
    logic       w_here;

    // Current content, with the accepted byte already placed at the fill count
    assign w_here     = i_ctl.insert && (i_count == CW'(IDX));
    assign o_eff_byte = w_here ? i_text_byte : r_byte;

    // Cells past the pattern length never veto a match
    assign o_match_ok = (CW'(IDX) >= i_len) || (o_eff_byte == i_pat_byte);

    // Advance from the right neighbor or keep the current content
    assign n_byte = i_ctl.shift ? i_right_byte : o_eff_byte;

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

endmodule

[rtl/pmf_seq.sv]
// ----------------------------------------------------------------------------
// pmf_seq: window sequencer and output register
// Tracks the fill count, star run and final flag, steers the cell row and
// produces at most one result per step into the output register.
// ----------------------------------------------------------------------------
module pmf_seq
    import pmf_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    localparam int CW = $clog2(MAX_PATTERN + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_final_byte,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [7:0]    o_out_byte,
    output logic          o_run_end,
    output logic          o_text_end,
    input  logic [CW-1:0] i_len,
    input  logic [7:0]    i_head_byte,
    input  logic          i_match,
    output t_cell_ctl     o_ctl,
    output logic [CW-1:0] o_count
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_BUSY = 2'b10
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_stars, n_stars;
    logic          r_fin, n_fin;
    logic          r_out_valid;
    logic [7:0]    r_out_byte, n_out_byte;
    logic          r_run_end, n_run_end;
    logic          r_text_end, n_text_end;

    logic          w_slot_free;
    logic          w_accept;
    logic          w_step;
    logic          w_emit;
    logic          w_last;
    logic          w_shift;
    logic [CW-1:0] w_cnt_eff;
    logic          w_fin_eff;

    // Take an item while idle and the output slot is empty or draining
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE) && w_slot_free;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_step      = w_accept || ((r_state == ST_BUSY) && w_slot_free);

    // Window view seen by this step: the accepted byte counts as pending
    assign w_cnt_eff = w_accept ? r_count + CW'(1) : r_count;
    assign w_fin_eff = w_accept ? i_final_byte : r_fin;

    // Decide the result, if any, of this step
    always_comb begin
        w_emit     = 1'b0;
        w_last     = 1'b0;
        w_shift    = 1'b0;
        n_count    = w_cnt_eff;
        n_stars    = r_stars;
        n_out_byte = i_head_byte;
        if (r_stars != '0) begin
            // Continue a star run; the window is already empty
            w_emit     = 1'b1;
            w_last     = (r_stars == CW'(1));
            n_stars    = r_stars - CW'(1);
            n_out_byte = STAR_BYTE;
        end else if (w_cnt_eff > i_len) begin
            // Length was shortened: drop the oldest byte unchanged
            w_emit  = 1'b1;
            w_shift = 1'b1;
            n_count = w_cnt_eff - CW'(1);
        end else if (w_cnt_eff == i_len) begin
            if (i_match) begin
                w_emit     = 1'b1;
                w_last     = (i_len == CW'(1));
                n_stars    = i_len - CW'(1);
                n_count    = '0;
                n_out_byte = STAR_BYTE;
            end else begin
                w_emit  = 1'b1;
                w_shift = 1'b1;
                w_last  = !w_fin_eff || (w_cnt_eff == CW'(1));
                n_count = w_cnt_eff - CW'(1);
            end
        end else if (w_fin_eff && (w_cnt_eff != '0)) begin
            // Flush the window at the end of the text
            w_emit  = 1'b1;
            w_shift = 1'b1;
            w_last  = (w_cnt_eff == CW'(1));
            n_count = w_cnt_eff - CW'(1);
        end
    end

    // Next control state
    always_comb begin
        n_state    = r_state;
        n_fin      = r_fin;
        n_run_end  = w_last;
        n_text_end = w_last && w_fin_eff;
        if (w_accept) begin
            n_fin = i_final_byte;
        end
        if (w_step) begin
            if (w_emit && !w_last) begin
                n_state = ST_BUSY;
            end else begin
                n_state = ST_IDLE;
            end
        end
    end

    assign o_ctl.insert = w_accept;
    assign o_ctl.shift  = w_step && w_shift;
    assign o_count      = r_count;

    // Hold control state; advance on a step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_stars     <= '0;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_step) begin
                r_state <= n_state;
                r_count <= n_count;
                r_stars <= n_stars;
                r_fin   <= n_fin;
            end
            if (w_step && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the output register with the new result
    always_ff @(posedge i_clk) begin
        if (w_step && w_emit) begin
            r_out_byte <= n_out_byte;
            r_run_end  <= n_run_end;
            r_text_end <= n_text_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_run_end   = r_run_end;
    assign o_text_end  = r_text_end;

`include "pattern_mask_filter_defines.svh"

    `PMF_ASSERT_NOW(a_count_in_range, 1'b1, r_count < CW'(MAX_PATTERN), "fill count overflow")
    `PMF_ASSERT_NOW(a_stars_empty_win, r_stars != '0, r_count == '0, "star run with pending bytes")
    `PMF_ASSERT_NOW(a_text_end_runs, o_out_valid && o_text_end, o_run_end, "text end without run end")
    `PMF_ASSERT_NEXT(a_flush_empties, w_step && w_emit && w_last && w_fin_eff, r_count == '0 && r_stars == '0, "window not empty after text end")

endmodule

[rtl/pattern_mask_filter.sv]
// ----------------------------------------------------------------------------
// pattern_mask_filter: streaming pattern masker
// Replaces every greedy, non-overlapping occurrence of the configured pattern
// in a byte stream by as many asterisks, using a row of byte cells.
//
//   channel   direction  signals
//   in        sink       i_in_valid, o_in_ready, i_text_byte, i_final_byte
//   out       source     o_out_valid, i_out_ready, o_out_byte, o_run_end, o_text_end
//   cfg       sink       i_cfg_we, i_cfg_idx, i_cfg_data (write only)
//
// An item that yields zero or one result leaves the sequencer idle; an item that
// yields several results holds o_in_ready low until its last result is loaded into
// the output register, one result per cycle while the output is not stalled.
// There is no clearing pass.
// Reset is synchronous and active low; it empties the window and output.
// A stalled output holds the register and, with it, the whole row.
// ----------------------------------------------------------------------------
module pattern_mask_filter
    import pmf_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_text_byte,
    input  logic                  i_final_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_out_byte,
    output logic                  o_run_end,
    output logic                  o_text_end,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_PATTERN + 1);

    logic [CW-1:0]          w_len;
    logic [7:0]             w_pat [MAX_PATTERN];
    logic [7:0]             w_eff [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] w_ok;
    logic                   w_match;
    t_cell_ctl              w_ctl;
    logic [CW-1:0]          w_count;

    pmf_cfg #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_len      (w_len),
        .o_pat      (w_pat)
    );

    // Row of cells, head at index zero
    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
        logic [7:0] w_right;
        if (g == MAX_PATTERN - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_mid
            assign w_right = w_eff[g + 1];
        end

        pmf_cell #(
            .MAX_PATTERN (MAX_PATTERN),
            .IDX         (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_count      (w_count),
            .i_len        (w_len),
            .i_text_byte  (i_text_byte),
            .i_pat_byte   (w_pat[g]),
            .i_right_byte (w_right),
            .o_eff_byte   (w_eff[g]),
            .o_match_ok   (w_ok[g])
        );
    end

    // Match when every cell inside the pattern length agrees
    assign w_match = &w_ok;

    pmf_seq #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_final_byte (i_final_byte),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_out_byte   (o_out_byte),
        .o_run_end    (o_run_end),
        .o_text_end   (o_text_end),
        .i_len        (w_len),
        .i_head_byte  (w_eff[0]),
        .i_match      (w_match),
        .o_ctl        (w_ctl),
        .o_count      (w_count)
    );

endmodule
